[rtl/symbol_clock_recovery_nco_assert.svh]
// Assertion macros for the symbol clock recovery block.
// Included by scrnco_core, which checks its own logic; needs nothing else.
`ifndef SYMBOL_CLOCK_RECOVERY_NCO_ASSERT_SVH
`define SYMBOL_CLOCK_RECOVERY_NCO_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCRNCO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scrnco check failed");

// next-cycle implication, checked outside reset
`define SCRNCO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scrnco check failed");

`endif

[rtl/scrnco_pkg.sv]
// Shared types and constants for the symbol clock recovery block.
// Used by the register file, the datapath and the top level.
package scrnco_pkg;

   localparam int SYMBOL_W = 8;
   localparam int REG_W    = 15;
   localparam int ERR_W    = 16;
   localparam int CNT_W    = 16;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [REG_W-1:0] PHASE_STEP_RESET   = 15'h0000;
   localparam logic [REG_W-1:0] TARGET_PHASE_RESET = 15'h4000;
   localparam logic [CNT_W-1:0] CNT_MAX            = 16'hffff;

   typedef enum logic [0:0] {
      REG_PHASE_STEP   = 1'b0,
      REG_TARGET_PHASE = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [REG_W-1:0] phase_step;
      logic [REG_W-1:0] target_phase;
   } cfg_type;

endpackage

[rtl/scrnco_csr.sv]
// Configuration registers: phase step and target phase behind an APB-style port.
// Depends on scrnco_pkg.
module scrnco_csr
   import scrnco_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (index)
         REG_PHASE_STEP: begin
            prdata = DATA_W'(cfg_ff.phase_step);
            if (wr_en) begin
               cfg_in.phase_step = pwdata[REG_W-1:0];
            end
         end
         REG_TARGET_PHASE: begin
            prdata = DATA_W'(cfg_ff.target_phase);
            if (wr_en) begin
               cfg_in.target_phase = pwdata[REG_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step   <= PHASE_STEP_RESET;
         cfg_ff.target_phase <= TARGET_PHASE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/scrnco_core.sv]
// Datapath: input register, phase accumulator loop, edge counter and result register.
// Depends on scrnco_pkg and symbol_clock_recovery_nco_assert.svh.
`include "symbol_clock_recovery_nco_assert.svh"
module scrnco_core
   import scrnco_pkg::*;
#(
   parameter int PHASE_BITS = 15
)
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_symbol,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_capture,
   output logic                rsp_edge_seen,
   output logic signed [ERR_W-1:0] rsp_phase_error,
   output logic [CNT_W-1:0]    rsp_samples_since_edge
);

   localparam int CALC_W = ((PHASE_BITS > ERR_W) ? PHASE_BITS : ERR_W) + 1;

   logic                  s1_valid_ff, s1_valid_in;
   logic [SYMBOL_W-1:0]   s1_symbol_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  capture_ff, edge_seen_ff;
   logic signed [ERR_W-1:0] rsp_err_ff;
   logic [CNT_W-1:0]      rsp_cnt_ff;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SYMBOL_W-1:0]   prev_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic [CNT_W-1:0]      dist_ff, dist_in;

   logic                  out_free, advance, accept, edge_hit, cap;
   logic [CALC_W-1:0]     diff, half_ext, pulled, sum;
   logic signed [ERR_W-1:0] err_now, half;
   logic [PHASE_BITS-1:0] phase_mid;
   logic [CNT_W-1:0]      dist_base;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      edge_hit  = s1_symbol_ff != prev_ff;
      diff      = CALC_W'(phase_ff) - CALC_W'(cfg.target_phase);
      err_now   = diff[ERR_W-1:0];
      half      = err_now >>> 1;
      half_ext  = {{(CALC_W-ERR_W){half[ERR_W-1]}}, half};
      pulled    = CALC_W'(phase_ff) - half_ext;
      phase_mid = edge_hit ? pulled[PHASE_BITS-1:0] : phase_ff;
      sum       = CALC_W'(phase_mid) + CALC_W'(cfg.phase_step);
      cap       = (sum >> PHASE_BITS) != '0;
      phase_in  = sum[PHASE_BITS-1:0];
      err_in    = edge_hit ? err_now : err_ff;
      dist_base = edge_hit ? '0 : dist_ff;
      dist_in   = (dist_base == CNT_MAX) ? dist_base : dist_base + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         prev_ff      <= '0;
         err_ff       <= '0;
         dist_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            prev_ff  <= s1_symbol_ff;
            err_ff   <= err_in;
            dist_ff  <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_symbol_ff <= req_symbol;
      end
      if (advance) begin
         capture_ff   <= cap;
         edge_seen_ff <= edge_hit;
         rsp_err_ff   <= err_in;
         rsp_cnt_ff   <= dist_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_capture            = capture_ff;
   assign rsp_edge_seen          = edge_seen_ff;
   assign rsp_phase_error        = rsp_err_ff;
   assign rsp_samples_since_edge = rsp_cnt_ff;

   `SCRNCO_ASSERT_NEXT(a_edge_count_one, clock, reset, advance && edge_hit, rsp_cnt_ff == 16'd1)
   `SCRNCO_ASSERT_NEXT(a_count_nonzero, clock, reset, advance, dist_ff != '0)
   `SCRNCO_ASSERT_NEXT(a_err_held, clock, reset, advance && !edge_hit, $stable(err_ff))
   `SCRNCO_ASSERT_NOW(a_full_stall, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)

endmodule

[rtl/symbol_clock_recovery_nco.sv]
// Symbol clock recovery NCO: takes one symbol per cycle while rsp_ready is high and
// returns one result per item, held first in the input register, then in the result
// register; the phase loop closes through the phase register alone, so items stream
// back to back. On a symbol change the phase is pulled toward target_phase by half the
// error; capture marks wraps. Depends on scrnco_pkg, scrnco_csr and scrnco_core.
module symbol_clock_recovery_nco
   import scrnco_pkg::*;
#(
   parameter int PHASE_BITS = 15
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_symbol,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_capture,
   output logic                rsp_edge_seen,
   output logic signed [ERR_W-1:0] rsp_phase_error,
   output logic [CNT_W-1:0]    rsp_samples_since_edge
);

   cfg_type cfg;

   scrnco_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scrnco_core #(
      .PHASE_BITS (PHASE_BITS)
   ) u_core (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_symbol             (req_symbol),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_capture            (rsp_capture),
      .rsp_edge_seen          (rsp_edge_seen),
      .rsp_phase_error        (rsp_phase_error),
      .rsp_samples_since_edge (rsp_samples_since_edge)
   );

endmodule
